// ----- sv/nmid_pkg.sv -----
// shared types and constants for the nco mix integrate-and-dump block
// no dependencies

package nmid_pkg;

  localparam int SampleW = 16;
  localparam int OscW    = 18;
  localparam int SumW    = 30;
  localparam int DecW    = 13;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 18;
  localparam int FracW   = 16;

  localparam int MaxDecimationDefault = 4096;

  localparam logic [CfgIdxW-1:0] CfgStepReal  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepImag  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDecimation = 2'd2;

  localparam logic signed [OscW-1:0] OscOne       = 18'sd65536;
  localparam logic [DecW-1:0]        DecimationRst = 13'd1;

  typedef struct packed {
    logic load_in;
    logic osc_mul;
    logic osc_upd;
    logic mix_mul;
    logic acc_en;
  } cmd_t;

  typedef struct packed {
    logic dump;
    logic out_busy;
  } status_t;

endpackage

// ----- sv/nco_mix_integrate_dump_core.sv -----
// top level of the nco mix integrate-and-dump block
// instantiates nmid_ctrl and nmid_dp; uses nmid_pkg
//
// usage:
//   s_axis carries one complex sample per item, m_axis one pair of sums per
//   decimation period. registers (step_real, step_imag, decimation) are
//   written through cfg_we_i / cfg_addr_i / cfg_wdata_i while the block is idle
//   (a duty of the user, not enforced by the block). each accepted item goes
//   through the accepting edge, oscillator multiply, oscillator round and
//   saturate, mix multiply and accumulate; this order is set by the oscillator
//   recursion, whose new value must be rounded before the sample can be mixed
//   with it. s_axis_tready is high only between items, so a new sample is
//   taken only after the last one is accumulated. a result is valid in the
//   cycle after its last sample's accumulate step and sits in an output
//   register; the next samples keep being taken while it waits, and only the
//   accumulate step that ends the next period holds until the pending result
//   is taken. reset sets the oscillator to 1+0j, clears accumulators and
//   count, and restores register defaults; no output is pending after reset.

module nco_mix_integrate_dump_core #(
  parameter int MaxDecimation = nmid_pkg::MaxDecimationDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nmid_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [nmid_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // sample_real, sample_imag
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata   // sum_real, sum_imag, zero pad
);
  import nmid_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic signed [SumW-1:0]  sum_real, sum_imag;

  nmid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nmid_dp #(
    .MaxDecimation (MaxDecimation)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_real_i (s_axis_tdata[SampleW-1:0]),
    .sample_imag_i (s_axis_tdata[2*SampleW-1:SampleW]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .sum_real_o    (sum_real),
    .sum_imag_o    (sum_imag)
  );

  assign m_axis_tdata = {{(64-2*SumW){1'b0}}, sum_imag, sum_real};

endmodule

// ----- sv/nmid_ctrl.sv -----
// sequencer for one sample: oscillator multiply, oscillator update,
// mix multiply, accumulate; uses nmid_pkg

module nmid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  nmid_pkg::status_t status_i,
  output nmid_pkg::cmd_t  cmd_o
);
  import nmid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OSC_MUL,
    S_OSC_SUM,
    S_MIX_MUL,
    S_ACCUM
  } state_e;

  state_e state_q;
  logic   acc_go;

  assign acc_go = !(status_i.dump && status_i.out_busy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:    if (in_valid_i) state_q <= S_OSC_MUL;
        S_OSC_MUL: state_q <= S_OSC_SUM;
        S_OSC_SUM: state_q <= S_MIX_MUL;
        S_MIX_MUL: state_q <= S_ACCUM;
        S_ACCUM:   if (acc_go) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.osc_mul   = (state_q == S_OSC_MUL);
  assign cmd_o.osc_upd   = (state_q == S_OSC_SUM);
  assign cmd_o.mix_mul   = (state_q == S_MIX_MUL);
  assign cmd_o.acc_en    = (state_q == S_ACCUM) && acc_go;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> state_q == S_OSC_MUL)
    else $error("accepted item did not start the sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_en |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after accumulate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCUM && !acc_go) |=> state_q == S_ACCUM)
    else $error("accumulate left while result slot blocked");

endmodule

// ----- sv/nmid_dp.sv -----
// datapath: config registers, recursive oscillator, mixer multipliers,
// accumulators, sample count and result register; uses nmid_pkg

module nmid_dp #(
  parameter int MaxDecimation = nmid_pkg::MaxDecimationDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nmid_pkg::CfgIdxW-1:0]         cfg_addr_i,
  input  logic [nmid_pkg::CfgW-1:0]            cfg_wdata_i,
  input  logic signed [nmid_pkg::SampleW-1:0]  sample_real_i,
  input  logic signed [nmid_pkg::SampleW-1:0]  sample_imag_i,
  input  nmid_pkg::cmd_t                       cmd_i,
  output nmid_pkg::status_t                    status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [nmid_pkg::SumW-1:0]     sum_real_o,
  output logic signed [nmid_pkg::SumW-1:0]     sum_imag_o
);
  import nmid_pkg::*;

  localparam int MaxW = $clog2(MaxDecimation + 1);
  localparam int EffW = (MaxW > DecW) ? MaxW : DecW;
  localparam int OscPW = 2 * OscW;
  localparam int MixPW = SampleW + OscW;
  localparam int OscNW = OscPW + 1 - FracW;
  localparam int MixNW = MixPW + 1 - FracW;

  logic signed [OscW-1:0]    step_real_q, step_imag_q;
  logic [DecW-1:0]           dec_q;
  logic signed [SampleW-1:0] xr_q, xi_q;
  logic signed [OscW-1:0]    osc_real_q, osc_imag_q;
  logic signed [OscPW-1:0]   p0_q, p1_q, p2_q, p3_q;
  logic signed [MixPW-1:0]   q0_q, q1_q, q2_q, q3_q;
  logic signed [SumW-1:0]    acc_real_q, acc_imag_q, acc_real_d, acc_imag_d;
  logic [DecW-1:0]           cnt_q, cnt_inc;
  logic                      out_valid_q;
  logic signed [SumW-1:0]    out_real_q, out_imag_q;

  logic signed [OscPW:0]     osc_sr, osc_si;
  logic signed [OscNW-1:0]   osc_nr, osc_ni;
  logic signed [OscW-1:0]    osc_real_d, osc_imag_d;
  logic signed [MixPW:0]     mix_sr, mix_si;
  logic signed [MixNW-1:0]   mix_r, mix_i;
  logic [EffW-1:0]           eff, dec_ext;
  logic                      dump;

  function automatic logic signed [OscW-1:0] sat_osc(input logic signed [OscNW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[OscNW-1:OscW-1];
    hi_zeros = ~|v[OscNW-1:OscW-1];
    if (hi_ones || hi_zeros) begin
      sat_osc = v[OscW-1:0];
    end else if (v[OscNW-1]) begin
      sat_osc = {1'b1, {(OscW-1){1'b0}}};
    end else begin
      sat_osc = {1'b0, {(OscW-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_real_q <= OscOne;
      step_imag_q <= '0;
      dec_q       <= DecimationRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgStepReal:   step_real_q <= cfg_wdata_i[OscW-1:0];
        CfgStepImag:   step_imag_q <= cfg_wdata_i[OscW-1:0];
        CfgDecimation: dec_q       <= cfg_wdata_i[DecW-1:0];
        default:       ;
      endcase
    end
  end

  // oscillator update
  assign osc_sr = {p0_q[OscPW-1], p0_q} - {p1_q[OscPW-1], p1_q};
  assign osc_si = {p2_q[OscPW-1], p2_q} + {p3_q[OscPW-1], p3_q};
  assign osc_nr = osc_sr[OscPW:FracW];
  assign osc_ni = osc_si[OscPW:FracW];
  assign osc_real_d = sat_osc(osc_nr);
  assign osc_imag_d = sat_osc(osc_ni);

  // mix and integrate
  assign mix_sr = {q0_q[MixPW-1], q0_q} - {q1_q[MixPW-1], q1_q};
  assign mix_si = {q2_q[MixPW-1], q2_q} + {q3_q[MixPW-1], q3_q};
  assign mix_r  = mix_sr[MixPW:FracW];
  assign mix_i  = mix_si[MixPW:FracW];
  assign acc_real_d = acc_real_q + {{(SumW-MixNW){mix_r[MixNW-1]}}, mix_r};
  assign acc_imag_d = acc_imag_q + {{(SumW-MixNW){mix_i[MixNW-1]}}, mix_i};

  // effective decimation and end of period
  assign dec_ext = EffW'(dec_q);
  always_comb begin
    priority if (dec_q == '0) begin
      eff = EffW'(1);
    end else if (dec_ext > EffW'(MaxDecimation)) begin
      eff = EffW'(MaxDecimation);
    end else begin
      eff = dec_ext;
    end
  end
  assign cnt_inc = cnt_q + DecW'(1);
  assign dump    = EffW'(cnt_inc) >= eff;

  assign status_o.dump     = dump;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xr_q <= sample_real_i;
      xi_q <= sample_imag_i;
    end
    if (cmd_i.osc_mul) begin
      p0_q <= step_real_q * osc_real_q;
      p1_q <= step_imag_q * osc_imag_q;
      p2_q <= step_real_q * osc_imag_q;
      p3_q <= step_imag_q * osc_real_q;
    end
    if (cmd_i.mix_mul) begin
      q0_q <= xr_q * osc_real_q;
      q1_q <= xi_q * osc_imag_q;
      q2_q <= xi_q * osc_real_q;
      q3_q <= xr_q * osc_imag_q;
    end
    if (cmd_i.acc_en && dump) begin
      out_real_q <= acc_real_d;
      out_imag_q <= acc_imag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_real_q  <= OscOne;
      osc_imag_q  <= '0;
      acc_real_q  <= '0;
      acc_imag_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.osc_upd) begin
        osc_real_q <= osc_real_d;
        osc_imag_q <= osc_imag_d;
      end
      if (cmd_i.acc_en) begin
        if (dump) begin
          acc_real_q <= '0;
          acc_imag_q <= '0;
          cnt_q      <= '0;
        end else begin
          acc_real_q <= acc_real_d;
          acc_imag_q <= acc_imag_d;
          cnt_q      <= cnt_inc;
        end
      end
      if (cmd_i.acc_en && dump) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_real_o  = out_real_q;
  assign sum_imag_o  = out_imag_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_en && dump) |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_en && dump) |=> (acc_real_q == '0 && acc_imag_q == '0 && cnt_q == '0))
    else $error("period not cleared after dump");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.acc_en && dump))
    else $error("result valid without a dump");

endmodule

// ----- dv/nmid_checker.sv -----
`timescale 1ns / 100ps
// checker for nco_mix_integrate_dump_core: tracks register writes and accepted samples,
// predicts every pair of sums and compares it with the output stream
// depends on nmid_pkg

module nmid_checker import nmid_pkg::*; #(
  parameter int MaxDecimation = MaxDecimationDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [31:0]        s_data_i,   // sample_real, sample_imag
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [63:0]        m_data_i,   // sum_real, sum_imag, zero pad
  output int                 pending_o,
  output int                 checked_o,
  output int                 errors_o
);

  localparam longint OscMax = (longint'(1) <<< (OscW - 1)) - 1;
  localparam longint OscMin = -(longint'(1) <<< (OscW - 1));
  localparam int     MaxPrints = 30;

  typedef struct packed {
    logic [SumW-1:0] sum_real;
    logic [SumW-1:0] sum_imag;
  } sums_t;

  sums_t sums_q[$];

  logic signed [OscW-1:0] step_re, step_im;
  logic signed [OscW-1:0] osc_re, osc_im;
  logic [SumW-1:0]        acc_re, acc_im;
  logic [DecW-1:0]        dec_reg, count;
  int                     errors, checked;

  function automatic logic signed [OscW-1:0] clamp_osc(input longint v);
    if (v > OscMax) return OscW'(OscMax);
    if (v < OscMin) return OscW'(OscMin);
    return OscW'(v);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MaxPrints) begin
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task automatic integrate_sample(input logic [31:0] data);
    longint xr, xi, sr, si, o_re, o_im, n_re, n_im, m_re, m_im;
    int     eff;
    xr   = longint'($signed(data[SampleW-1:0]));
    xi   = longint'($signed(data[2*SampleW-1:SampleW]));
    sr   = longint'(step_re);
    si   = longint'(step_im);
    o_re = longint'(osc_re);
    o_im = longint'(osc_im);
    n_re = (sr * o_re - si * o_im) >>> FracW;
    n_im = (sr * o_im + si * o_re) >>> FracW;
    osc_re = clamp_osc(n_re);
    osc_im = clamp_osc(n_im);
    o_re = longint'(osc_re);
    o_im = longint'(osc_im);
    m_re = (xr * o_re - xi * o_im) >>> FracW;
    m_im = (xi * o_re + xr * o_im) >>> FracW;
    acc_re = acc_re + SumW'(m_re);
    acc_im = acc_im + SumW'(m_im);
    eff = int'(dec_reg);
    if (eff == 0) eff = 1;
    if (eff > MaxDecimation) eff = MaxDecimation;
    count = count + 1'b1;
    if (int'(count) >= eff) begin
      sums_q.push_back('{sum_real: acc_re, sum_imag: acc_im});
      acc_re = '0;
      acc_im = '0;
      count  = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sums_t want;
    if (!rst_ni) begin
      sums_q.delete();
      step_re   = OscOne;
      step_im   = '0;
      dec_reg   = DecimationRst;
      osc_re    = OscOne;
      osc_im    = '0;
      acc_re    = '0;
      acc_im    = '0;
      count     = '0;
      errors    = 0;
      checked   = 0;
      pending_o <= 0;
      checked_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgStepReal:   step_re = cfg_wdata_i;
          CfgStepImag:   step_im = cfg_wdata_i;
          CfgDecimation: dec_reg = cfg_wdata_i[DecW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) integrate_sample(s_data_i);
      if (m_valid_i && m_ready_i) begin
        if (sums_q.size() == 0) begin
          report_mismatch("unexpected sum item", m_data_i, '0);
        end else begin
          want = sums_q.pop_front();
          checked++;
          if (m_data_i[SumW-1:0] !== want.sum_real)
            report_mismatch("sum_real", m_data_i[SumW-1:0], want.sum_real);
          if (m_data_i[2*SumW-1:SumW] !== want.sum_imag)
            report_mismatch("sum_imag", m_data_i[2*SumW-1:SumW], want.sum_imag);
          if (m_data_i[63:2*SumW] !== '0)
            report_mismatch("pad bits", m_data_i[63:2*SumW], '0);
        end
      end
      pending_o <= sums_q.size();
      checked_o <= checked;
      errors_o  <= errors;
    end
  end

endmodule

// ----- dv/tb_nco_mix_integrate_dump_core.sv -----
`timescale 1ns / 100ps
// testbench top for nco_mix_integrate_dump_core: drives samples, register settings and
// output backpressure, and gives the verdict; checking lives in nmid_checker
// depends on nmid_pkg, nmid_checker and the core

module tb_nco_mix_integrate_dump_core;
  import nmid_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int SettleCycles = 12;
  localparam int RxHoldCycles = 300;
  localparam int StallLimit   = 3000;
  localparam int RandomItems  = 1340;
  localparam int LongPeriod   = 300;

  localparam logic [CfgW-1:0]    StepOne    = CfgW'(65536);
  localparam logic [CfgW-1:0]    StepNegOne = CfgW'(-65536);
  localparam logic [CfgW-1:0]    StepMax    = 18'h1FFFF;
  localparam logic [CfgW-1:0]    StepMin    = 18'h20000;
  localparam logic [CfgW-1:0]    StepDiag   = CfgW'(46341);
  localparam logic [SampleW-1:0] SampMax    = 16'h7FFF;
  localparam logic [SampleW-1:0] SampMin    = 16'h8000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [CfgW-1:0]   cfg_wdata = '0;
  logic              s_valid   = 1'b0;
  logic              s_ready;
  logic [31:0]       s_data    = '0;
  logic              m_valid;
  logic              m_ready   = 1'b0;
  logic [63:0]       m_data;
  logic              rx_steady = 1'b1;
  logic              rx_hold   = 1'b0;

  int pending, checked, errors;
  int n_sent     = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nco_mix_integrate_dump_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  nmid_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .pending_o   (pending),
    .checked_o   (checked),
    .errors_o    (errors)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SampMax;
      1: return SampMin;
      2: return '0;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return StepOne;
      1: return StepNegOne;
      2: return StepMax;
      3: return StepMin;
      4: return '0;
      5: return CfgW'($urandom);
      default: return CfgW'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [DecW-1:0] pick_decimation();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DecW'($urandom_range(13, 40));
      default: return DecW'($urandom_range(1, 12));
    endcase
  endfunction

  // output side: random stalls, steady stretches and one long hold-off on request
  initial begin : rx_proc
    int stall;
    bit hold_done;
    stall     = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold && !hold_done) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk);
        m_ready <= 1'b1;
      end else if (stall > 0) begin
        m_ready <= 1'b0;
        stall--;
      end else begin
        m_ready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t watchdog: no item moved for %0d cycles", $realtime, StallLimit);
      $display("tb_nco_mix_integrate_dump_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] re, input logic [SampleW-1:0] im);
    s_valid <= 1'b1;
    s_data  <= {im, re};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic sender_gap(input bit steady);
    int g;
    g = steady ? 0 : pick_gap();
    if (g > 0) begin
      s_valid <= 1'b0;
      s_data  <= $urandom;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic run_phase(input int n, input bit steady);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_sample(), pick_sample());
      sender_gap(steady);
    end
  endtask

  // wait for every sum, then let samples that end no period leave the pipeline
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CfgW-1:0] sr, input logic [CfgW-1:0] si,
                              input logic [DecW-1:0] dec, input bit junk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CfgStepReal;
    cfg_wdata <= sr;
    @(posedge clk);
    cfg_addr  <= CfgStepImag;
    cfg_wdata <= si;
    @(posedge clk);
    cfg_addr  <= CfgDecimation;
    cfg_wdata <= {(CfgW-DecW)'($urandom), dec};
    @(posedge clk);
    if (junk) begin
      cfg_addr  <= CfgUnused;
      cfg_wdata <= CfgW'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults, extreme samples
    send_sample(SampMax, SampMax);
    send_sample(SampMin, SampMin);
    send_sample(SampMax, SampMin);
    send_sample(SampMin, SampMax);
    send_sample('0, '0);
    drain();

    // growing step drives the oscillator into saturation, decimation of zero
    program_regs(StepMax, StepMin, '0, 1'b1);
    send_sample(SampMin, SampMax);
    send_sample(SampMax, SampMin);
    send_sample(SampMin, SampMin);
    send_sample(SampMax, SampMax);
    send_sample(16'h0001, 16'hFFFF);
    drain();

    // decimation lowered below the count already reached
    program_regs(StepNegOne, '0, 13'd10, 1'b0);
    run_phase(7, 1'b1);
    drain();
    program_regs(StepNegOne, '0, 13'd3, 1'b0);
    run_phase(4, 1'b1);
    drain();

    // unit-magnitude rotation
    program_regs(StepDiag, StepDiag, 13'd2, 1'b0);
    run_phase(4, 1'b1);
    drain();

    // long output hold-off while samples keep coming
    rx_steady <= 1'b0;
    program_regs(pick_step(), pick_step(), 13'd1, 1'b0);
    rx_hold <= 1'b1;
    run_phase(40, 1'b1);
    drain();

    while (n_sent < RandomItems) begin
      program_regs(pick_step(), pick_step(), pick_decimation(), $urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 4) == 0);
      run_phase($urandom_range(5, 60), $urandom_range(0, 4) == 0);
      drain();
    end

    // decimation above the maximum: a long open period, ended by the next setting
    program_regs(StepMax, StepNegOne, 13'h1FFF, 1'b0);
    rx_steady <= 1'b0;
    run_phase(LongPeriod, 1'b0);
    drain();

    program_regs(StepOne, '0, 13'd1, 1'b0);
    run_phase(10, 1'b0);
    drain();
    repeat (SettleCycles) @(posedge clk);

    $display("sent %0d samples over %0d register settings, %0d sums compared",
             n_sent, n_settings, checked);
    $display("covered extremes, oscillator saturation, zero and oversized decimation");
    if (errors == 0 && pending == 0) begin
      $display("tb_nco_mix_integrate_dump_core OK");
    end else begin
      $display("tb_nco_mix_integrate_dump_core NOT OK");
    end
    $finish;
  end

endmodule
